// ===== rtl/core/vcdu_pkg.sv =====
// Shared types and constants of the differential vector clock block.
package vcdu_pkg;

   localparam int MAX_NODES_DEF  = 16;
   localparam int CLOCK_BITS_DEF = 32;

   localparam int OWN_ID_W     = 4;
   localparam int NODE_COUNT_W = 5;
   localparam int CSR_DATA_W   = 5;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0]  CSR_OWN_ID        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0]  CSR_NODE_COUNT    = 2'd1;
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET  = 5'd16;

   typedef enum logic [1:0] {
      ACT_INTERNAL   = 2'd0,
      ACT_SEND       = 2'd1,
      ACT_RECV_BEGIN = 2'd2,
      ACT_RECV_TUPLE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS_A,
      ST_PASS_B,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic pass_a;
      logic pass_b;
      logic flush;
   } ctrl_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  dest_slot;
      logic [3:0]  entry;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]  tuple_entry;
      logic [31:0] tuple_value;
      logic        last_tuple;
   } rsp_type;

endpackage

// ===== rtl/core/vcdu_cell.sv =====
// One ring cell: holds the clock entry, update mark and sent mark of one process index.
module vcdu_cell #(
   parameter int IDX_W      = 4,
   parameter int CLOCK_BITS = vcdu_pkg::CLOCK_BITS_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic [IDX_W-1:0]      in_idx,
   input  logic [CLOCK_BITS-1:0] in_clk,
   input  logic [CLOCK_BITS-1:0] in_upd,
   input  logic [CLOCK_BITS-1:0] in_sent,
   output logic [IDX_W-1:0]      out_idx,
   output logic [CLOCK_BITS-1:0] out_clk,
   output logic [CLOCK_BITS-1:0] out_upd,
   output logic [CLOCK_BITS-1:0] out_sent
);

   logic [IDX_W-1:0]      idx_ff;
   logic [CLOCK_BITS-1:0] clk_ff;
   logic [CLOCK_BITS-1:0] upd_ff;
   logic [CLOCK_BITS-1:0] sent_ff;

   // The record carries its own index around the ring; after reset the cell holds the
   // index given by CELL_INDEX.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= IDX_W'(CELL_INDEX);
         clk_ff  <= '0;
         upd_ff  <= '0;
         sent_ff <= '0;
      end else if (shift) begin
         idx_ff  <= in_idx;
         clk_ff  <= in_clk;
         upd_ff  <= in_upd;
         sent_ff <= in_sent;
      end
   end

   assign out_idx  = idx_ff;
   assign out_clk  = clk_ff;
   assign out_upd  = upd_ff;
   assign out_sent = sent_ff;

endmodule

// ===== rtl/core/vcdu_scan.sv =====
// Ring join: updates the record passing from the last cell to the first and emits tuples.
module vcdu_scan #(
   parameter int IDX_W      = 4,
   parameter int CLOCK_BITS = vcdu_pkg::CLOCK_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vcdu_pkg::ctrl_type                   ctrl,
   input  vcdu_pkg::req_type                    item,
   input  logic [vcdu_pkg::OWN_ID_W-1:0]        own_id,
   input  logic [vcdu_pkg::NODE_COUNT_W-1:0]    node_count,
   input  logic [IDX_W-1:0]                     rec_idx,
   input  logic [CLOCK_BITS-1:0]                rec_clk,
   input  logic [CLOCK_BITS-1:0]                rec_upd,
   input  logic [CLOCK_BITS-1:0]                rec_sent,
   output logic [CLOCK_BITS-1:0]                new_clk,
   output logic [CLOCK_BITS-1:0]                new_upd,
   output logic [CLOCK_BITS-1:0]                new_sent,
   output logic                                 rsp_strobe,
   output vcdu_pkg::rsp_type                    rsp_word
);

   localparam int CMP_W = (IDX_W > vcdu_pkg::NODE_COUNT_W) ? IDX_W : vcdu_pkg::NODE_COUNT_W;

   logic [CMP_W-1:0]      idx_x;
   logic                  own_hit;
   logic                  slot_hit;
   logic                  entry_hit;
   logic                  in_use;
   logic                  raise_op;
   logic                  is_send;
   logic                  is_tuple;
   logic [CLOCK_BITS-1:0] clk_inc;
   logic [CLOCK_BITS-1:0] val_sat;
   logic                  cand;

   logic [CLOCK_BITS-1:0] own_clk_ff,  own_clk_in;
   logic [CLOCK_BITS-1:0] mark_ff,     mark_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [3:0]            pend_ent_ff, pend_ent_in;
   logic [31:0]           pend_val_ff, pend_val_in;
   logic                  rsp_vld_ff,  rsp_vld_in;
   vcdu_pkg::rsp_type     rsp_word_ff, rsp_word_in;

   generate
      if (CLOCK_BITS >= 32) begin : g_wide
         assign val_sat = CLOCK_BITS'(item.value);
      end else begin : g_narrow
         assign val_sat = ((item.value >> CLOCK_BITS) != 32'd0) ? '1
                                                                 : item.value[CLOCK_BITS-1:0];
      end
   endgenerate

   assign idx_x     = CMP_W'(rec_idx);
   assign own_hit   = (idx_x == CMP_W'(own_id));
   assign slot_hit  = (idx_x == CMP_W'(item.dest_slot));
   assign entry_hit = (idx_x == CMP_W'(item.entry));
   assign in_use    = (idx_x < CMP_W'(node_count));
   assign is_send   = (item.action == vcdu_pkg::ACT_SEND);
   assign is_tuple  = (item.action == vcdu_pkg::ACT_RECV_TUPLE);
   assign raise_op  = (item.action == vcdu_pkg::ACT_INTERNAL) || is_send ||
                      (item.action == vcdu_pkg::ACT_RECV_BEGIN);
   assign clk_inc   = (rec_clk == '1) ? rec_clk : rec_clk + CLOCK_BITS'(1);
   assign cand      = ctrl.pass_b && is_send && in_use && (rec_upd > mark_ff);

   // Record rewrite: the first pass raises the own entry, the second merges or marks the slot.
   always_comb begin
      new_clk  = rec_clk;
      new_upd  = rec_upd;
      new_sent = rec_sent;
      if (ctrl.pass_a && raise_op && own_hit) begin
         new_clk = clk_inc;
         new_upd = clk_inc;
      end
      if (ctrl.pass_b && is_send && slot_hit) begin
         new_sent = own_clk_ff;
      end
      if (ctrl.pass_b && is_tuple && entry_hit && in_use && (rec_clk < val_sat)) begin
         new_clk = val_sat;
         new_upd = own_hit ? val_sat : own_clk_ff;
      end
   end

   // The first pass captures the own clock after raising and the sent mark of the slot.
   always_comb begin
      own_clk_in = own_clk_ff;
      mark_in    = mark_ff;
      if (ctrl.load) begin
         own_clk_in = '0;
         mark_in    = '0;
      end else if (ctrl.pass_a) begin
         if (own_hit) begin
            own_clk_in = raise_op ? clk_inc : rec_clk;
         end
         if (slot_hit) begin
            mark_in = rec_sent;
         end
      end
   end

   // A qualifying tuple waits in the pending stage until the next one or the end of the
   // scan shows whether it is the last word of the send.
   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_ent_in = pend_ent_ff;
      pend_val_in = pend_val_ff;
      rsp_vld_in  = 1'b0;
      rsp_word_in = rsp_word_ff;
      if (cand) begin
         if (pend_vld_ff) begin
            rsp_vld_in              = 1'b1;
            rsp_word_in.tuple_entry = pend_ent_ff;
            rsp_word_in.tuple_value = pend_val_ff;
            rsp_word_in.last_tuple  = 1'b0;
         end
         pend_vld_in = 1'b1;
         pend_ent_in = 4'(rec_idx);
         pend_val_in = 32'(rec_clk);
      end else if (ctrl.flush && pend_vld_ff) begin
         rsp_vld_in              = 1'b1;
         rsp_word_in.tuple_entry = pend_ent_ff;
         rsp_word_in.tuple_value = pend_val_ff;
         rsp_word_in.last_tuple  = 1'b1;
         pend_vld_in             = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      own_clk_ff  <= own_clk_in;
      mark_ff     <= mark_in;
      pend_ent_ff <= pend_ent_in;
      pend_val_ff <= pend_val_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== rtl/core/vcdu_ctrl.sv =====
// Sequencer: runs the ring passes of one item and counts the cells.
module vcdu_ctrl #(
   parameter int MAX_NODES = vcdu_pkg::MAX_NODES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  vcdu_pkg::action_type action,
   output vcdu_pkg::ctrl_type   ctrl,
   output logic                 busy
);

   localparam int CNT_W = $clog2(MAX_NODES);

   vcdu_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                cnt_last;
   logic                second_pass;

   assign cnt_last    = (cnt_ff == CNT_W'(MAX_NODES - 1));
   assign second_pass = (action == vcdu_pkg::ACT_SEND) ||
                        (action == vcdu_pkg::ACT_RECV_TUPLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vcdu_pkg::ST_IDLE: begin
            if (start) begin
               state_in = vcdu_pkg::ST_PASS_A;
            end
         end
         vcdu_pkg::ST_PASS_A: begin
            if (cnt_last) begin
               state_in = second_pass ? vcdu_pkg::ST_PASS_B : vcdu_pkg::ST_IDLE;
            end
         end
         vcdu_pkg::ST_PASS_B: begin
            if (cnt_last) begin
               state_in = (action == vcdu_pkg::ACT_SEND) ? vcdu_pkg::ST_FLUSH
                                                         : vcdu_pkg::ST_IDLE;
            end
         end
         vcdu_pkg::ST_FLUSH: begin
            state_in = vcdu_pkg::ST_IDLE;
         end
         default: begin
            state_in = vcdu_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl   = '0;
      busy   = 1'b1;
      cnt_in = '0;
      case (state_ff)
         vcdu_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         vcdu_pkg::ST_PASS_A: begin
            ctrl.shift  = 1'b1;
            ctrl.pass_a = 1'b1;
            cnt_in      = cnt_last ? '0 : cnt_ff + CNT_W'(1);
         end
         vcdu_pkg::ST_PASS_B: begin
            ctrl.shift  = 1'b1;
            ctrl.pass_b = 1'b1;
            cnt_in      = cnt_last ? '0 : cnt_ff + CNT_W'(1);
         end
         vcdu_pkg::ST_FLUSH: begin
            ctrl.flush = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vcdu_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/vector_clock_differential_update.sv =====
// Top level of the differential vector clock: registers, sequencer, cell ring and join.
//
// The block keeps one process's vector clock with update and sent marks in a ring of
// MAX_NODES cells. A command word on req_word is taken when start is high and busy is low.
// Every record circulates once per pass, one cell per cycle, through the join logic:
//   internal event, receive begin: one pass;
//   received tuple: two passes;
//   send: two passes and a flush step.
// A send emits its tuples during the second pass in entry order. Each tuple is held until
// the next one qualifies, so words arrive on rsp_word with rsp_strobe high for one cycle
// each, the one flagged last_tuple in the first cycle with busy low. A send with nothing
// to report produces no word. The receiver cannot stall: a word is taken in the cycle it
// is shown. The csr port writes own_id (index 0) and node_count (index 1);
// it is meant to be used only while the block is idle. Synchronous reset clears all
// clocks and marks, sets own_id to 0 and node_count to 16, and the block takes a command
// in the first cycle after reset.
module vector_clock_differential_update #(
   parameter int MAX_NODES  = vcdu_pkg::MAX_NODES_DEF,
   parameter int CLOCK_BITS = vcdu_pkg::CLOCK_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  vcdu_pkg::req_type                    req_word,
   output logic                                 rsp_strobe,
   output vcdu_pkg::rsp_type                    rsp_word,
   input  logic                                 csr_we,
   input  logic [vcdu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vcdu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(MAX_NODES);

   vcdu_pkg::ctrl_type                    ctrl;
   vcdu_pkg::req_type                     req_ff;
   logic [vcdu_pkg::OWN_ID_W-1:0]         own_id_ff, own_id_in;
   logic [vcdu_pkg::NODE_COUNT_W-1:0]     node_count_ff, node_count_in;

   logic [IDX_W-1:0]      c_idx  [MAX_NODES];
   logic [CLOCK_BITS-1:0] c_clk  [MAX_NODES];
   logic [CLOCK_BITS-1:0] c_upd  [MAX_NODES];
   logic [CLOCK_BITS-1:0] c_sent [MAX_NODES];
   logic [CLOCK_BITS-1:0] j_clk;
   logic [CLOCK_BITS-1:0] j_upd;
   logic [CLOCK_BITS-1:0] j_sent;

   always_comb begin
      own_id_in     = own_id_ff;
      node_count_in = node_count_ff;
      if (csr_we) begin
         case (csr_index)
            vcdu_pkg::CSR_OWN_ID:     own_id_in     = csr_wdata[vcdu_pkg::OWN_ID_W-1:0];
            vcdu_pkg::CSR_NODE_COUNT: node_count_in = csr_wdata;
            default:                  own_id_in     = own_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= '0;
         node_count_ff <= vcdu_pkg::NODE_COUNT_RESET;
      end else begin
         own_id_ff     <= own_id_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_word;
      end
   end

   vcdu_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_ff.action),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   vcdu_scan #(
      .IDX_W      (IDX_W),
      .CLOCK_BITS (CLOCK_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .item       (req_ff),
      .own_id     (own_id_ff),
      .node_count (node_count_ff),
      .rec_idx    (c_idx[MAX_NODES-1]),
      .rec_clk    (c_clk[MAX_NODES-1]),
      .rec_upd    (c_upd[MAX_NODES-1]),
      .rec_sent   (c_sent[MAX_NODES-1]),
      .new_clk    (j_clk),
      .new_upd    (j_upd),
      .new_sent   (j_sent),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // The last cell feeds the join, whose rewritten record enters the first cell. Indexes
   // are laid out in descending order along the ring so that the join sees the entries
   // in ascending order during each pass.
   generate
      for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
         if (i == 0) begin : g_head
            vcdu_cell #(
               .IDX_W      (IDX_W),
               .CLOCK_BITS (CLOCK_BITS),
               .CELL_INDEX (MAX_NODES - 1 - i)
            ) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (ctrl.shift),
               .in_idx   (c_idx[MAX_NODES-1]),
               .in_clk   (j_clk),
               .in_upd   (j_upd),
               .in_sent  (j_sent),
               .out_idx  (c_idx[i]),
               .out_clk  (c_clk[i]),
               .out_upd  (c_upd[i]),
               .out_sent (c_sent[i])
            );
         end else begin : g_body
            vcdu_cell #(
               .IDX_W      (IDX_W),
               .CLOCK_BITS (CLOCK_BITS),
               .CELL_INDEX (MAX_NODES - 1 - i)
            ) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (ctrl.shift),
               .in_idx   (c_idx[i-1]),
               .in_clk   (c_clk[i-1]),
               .in_upd   (c_upd[i-1]),
               .in_sent  (c_sent[i-1]),
               .out_idx  (c_idx[i]),
               .out_clk  (c_clk[i]),
               .out_upd  (c_upd[i]),
               .out_sent (c_sent[i])
            );
         end
      end
   endgenerate

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the differential vector clock block.
`timescale 1ns / 100ps

module testbench;

   localparam int NODES   = vcdu_pkg::MAX_NODES_DEF;
   localparam int DRAIN   = 2 * NODES + 8;
   localparam logic [vcdu_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [vcdu_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   // Tracks the clock, update marks and sent marks, and queues the tuples a send must emit.
   class vclock_scoreboard;
      logic [31:0] clk_vec [NODES];
      logic [31:0] upd_mark [NODES];
      logic [31:0] sent_mark [NODES];
      logic [vcdu_pkg::OWN_ID_W-1:0] own_id;
      logic [vcdu_pkg::NODE_COUNT_W-1:0] node_count;
      vcdu_pkg::rsp_type pending_tuples [$];
      int errors;
      int commands;
      int tuples_seen;

      function new();
         for (int i = 0; i < NODES; i++) begin
            clk_vec[i] = '0;
            upd_mark[i] = '0;
            sent_mark[i] = '0;
         end
         own_id = '0;
         node_count = vcdu_pkg::NODE_COUNT_RESET;
         errors = 0;
         commands = 0;
         tuples_seen = 0;
      endfunction

      function void write_reg(logic [vcdu_pkg::CSR_INDEX_W-1:0] idx,
                              logic [vcdu_pkg::CSR_DATA_W-1:0] data);
         if (idx == vcdu_pkg::CSR_OWN_ID) begin
            own_id = data[vcdu_pkg::OWN_ID_W-1:0];
         end else if (idx == vcdu_pkg::CSR_NODE_COUNT) begin
            node_count = data[vcdu_pkg::NODE_COUNT_W-1:0];
         end
      endfunction

      function int used();
         return (node_count > NODES) ? NODES : int'(node_count);
      endfunction

      function void bump_own();
         if (clk_vec[own_id] != 32'hFFFF_FFFF) begin
            clk_vec[own_id] = clk_vec[own_id] + 32'd1;
         end
         upd_mark[own_id] = clk_vec[own_id];
      endfunction

      function void apply_command(vcdu_pkg::req_type w);
         logic [31:0] mark;
         vcdu_pkg::rsp_type t;
         int last_z;
         int z;
         commands++;
         case (w.action)
            vcdu_pkg::ACT_INTERNAL, vcdu_pkg::ACT_RECV_BEGIN: begin
               bump_own();
            end
            vcdu_pkg::ACT_SEND: begin
               bump_own();
               mark = sent_mark[w.dest_slot];
               last_z = -1;
               for (z = 0; z < used(); z++) begin
                  if (upd_mark[z] > mark) last_z = z;
               end
               for (z = 0; z < used(); z++) begin
                  if (upd_mark[z] > mark) begin
                     t.tuple_entry = 4'(z);
                     t.tuple_value = clk_vec[z];
                     t.last_tuple = (z == last_z);
                     pending_tuples = {pending_tuples, t};
                  end
               end
               sent_mark[w.dest_slot] = clk_vec[own_id];
            end
            default: begin
               if (int'(w.entry) < used() && clk_vec[w.entry] < w.value) begin
                  clk_vec[w.entry] = w.value;
                  upd_mark[w.entry] = clk_vec[own_id];
               end
            end
         endcase
      endfunction

      function void check_tuple(vcdu_pkg::rsp_type got);
         vcdu_pkg::rsp_type want;
         tuples_seen++;
         if (pending_tuples.size() == 0) begin
            $error("unexpected tuple: entry %0d value %0h last %0b",
                   got.tuple_entry, got.tuple_value, got.last_tuple);
            errors++;
            return;
         end
         want = pending_tuples.pop_front();
         if (got.tuple_entry !== want.tuple_entry) begin
            $error("tuple_entry: expected %0d, actual %0d", want.tuple_entry, got.tuple_entry);
            errors++;
         end
         if (got.tuple_value !== want.tuple_value) begin
            $error("tuple_value: expected %0h, actual %0h", want.tuple_value, got.tuple_value);
            errors++;
         end
         if (got.last_tuple !== want.last_tuple) begin
            $error("last_tuple: expected %0b, actual %0b", want.last_tuple, got.last_tuple);
            errors++;
         end
      endfunction

      function int pending();
         return pending_tuples.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   vcdu_pkg::req_type                req_word = '0;
   logic                             rsp_strobe;
   vcdu_pkg::rsp_type                rsp_word;
   logic                             csr_we = 1'b0;
   logic [vcdu_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [vcdu_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   vclock_scoreboard sb;
   int settings;

   vector_clock_differential_update u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[vector_clock_differential_update] ERROR");
      $finish;
   end

   // Everything is sampled at the edge, so all values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.apply_command(req_word);
         if (rsp_strobe) sb.check_tuple(rsp_word);
      end
   end

   task issue(vcdu_pkg::action_type act, logic [3:0] slot, logic [3:0] ent,
              logic [31:0] val);
      vcdu_pkg::req_type w;
      w.action = act;
      w.dest_slot = slot;
      w.entry = ent;
      w.value = val;
      req_word <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Waits for every queued tuple, then lets a send that reports nothing run out.
   task settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // The last write goes to a spare index, which the block must ignore.
   task configure(logic [vcdu_pkg::CSR_DATA_W-1:0] own_data,
                  logic [vcdu_pkg::CSR_DATA_W-1:0] count_data);
      settings++;
      csr_we <= 1'b1;
      csr_index <= vcdu_pkg::CSR_OWN_ID;
      csr_wdata <= own_data;
      @(posedge clock);
      csr_index <= vcdu_pkg::CSR_NODE_COUNT;
      csr_wdata <= count_data;
      @(posedge clock);
      csr_index <= ($urandom_range(0, 1) != 0) ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata <= vcdu_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly values near the current entry, so that merges both win and lose.
   function automatic logic [31:0] pick_value(logic [3:0] ent);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return $urandom;
      if (roll == 1) return '0;
      return sb.clk_vec[ent] + 32'($urandom_range(0, 12)) - 32'd4;
   endfunction

   task run_traffic(int n_items);
      int done;
      int burst;
      int k;
      int tuples;
      logic [3:0] ent;
      done = 0;
      while (done < n_items) begin
         burst = $urandom_range(1, 6);
         for (k = 0; k < burst; k++) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  issue(vcdu_pkg::ACT_INTERNAL, 4'($urandom), 4'($urandom), $urandom);
                  done++;
               end
               2, 3, 4: begin
                  issue(vcdu_pkg::ACT_SEND, 4'($urandom), 4'($urandom), $urandom);
                  done++;
               end
               5, 6, 7, 8: begin
                  // A well-formed message: receive begin, then its tuples.
                  issue(vcdu_pkg::ACT_RECV_BEGIN, 4'($urandom), 4'($urandom), $urandom);
                  tuples = $urandom_range(1, 4);
                  repeat (tuples) begin
                     ent = 4'($urandom);
                     issue(vcdu_pkg::ACT_RECV_TUPLE, 4'($urandom), ent, pick_value(ent));
                  end
                  done += tuples + 1;
               end
               default: begin
                  issue(vcdu_pkg::action_type'($urandom_range(0, 3)), 4'($urandom),
                        4'($urandom), $urandom);
                  done++;
               end
            endcase
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 45));
      end
      start <= 1'b0;
   endtask

   initial begin
      sb = new();
      settings = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: own entry 0, all sixteen entries in use.
      issue(vcdu_pkg::ACT_INTERNAL, 4'h0, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'h0, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'h0, 4'hF, 32'hFFFF_FFFF);
      issue(vcdu_pkg::ACT_RECV_BEGIN, 4'hF, 4'hF, 32'h0);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'd5, 32'd100);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'd5, 32'd50);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'd14, 32'hFFFF_FFFF);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'd3, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'hF, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'd7, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'd7, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_INTERNAL, 4'h0, 4'h0, 32'h0);
      start <= 1'b0;
      settle();

      // Entry 14 already sits at the maximum, so raising it must saturate, and a
      // second send to the same slot finds nothing newer than its sent mark.
      configure(5'd14, 5'd16);
      issue(vcdu_pkg::ACT_INTERNAL, 4'h0, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'hF, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_SEND, 4'hF, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'd2, 32'd10);
      start <= 1'b0;
      settle();

      // No entries in use: a send reports nothing and every tuple is dropped.
      configure(5'b10011, 5'd0);
      issue(vcdu_pkg::ACT_SEND, 4'd8, 4'h0, 32'h0);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'h0, 32'd99);
      start <= 1'b0;
      settle();

      // A count above the vector size is limited to all sixteen entries.
      configure(5'b10011, 5'd31);
      issue(vcdu_pkg::ACT_SEND, 4'd8, 4'h0, 32'h0);
      start <= 1'b0;
      settle();

      // One entry in use: the own entry 3 lies outside and a tuple to entry 1 is dropped.
      configure(5'b10011, 5'd1);
      issue(vcdu_pkg::ACT_RECV_TUPLE, 4'h0, 4'd1, 32'd50);
      issue(vcdu_pkg::ACT_SEND, 4'd9, 4'h0, 32'h0);
      start <= 1'b0;
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(5'd5, 5'd16);
            1: configure(5'd9, 5'd3);
            2: configure(5'($urandom_range(0, 31)), 5'd31);
            3: configure(5'd0, 5'($urandom_range(2, 15)));
            4: configure(5'b11111, 5'd16);
            default: configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
         endcase
         run_traffic(34);
         settle();
      end

      $display("Ran %0d commands under %0d register settings; %0d tuples compared.",
               sb.commands, settings, sb.tuples_seen);
      if (sb.errors == 0) begin
         $display("[vector_clock_differential_update] OK");
      end else begin
         $display("[vector_clock_differential_update] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/vcdu_pkg.sv
rtl/core/vcdu_cell.sv
rtl/core/vcdu_scan.sv
rtl/core/vcdu_ctrl.sv
rtl/core/vector_clock_differential_update.sv
tb/sv/testbench.sv
